// ===== src/matrix3x3_inverse_defines.svh =====
// Assertion macros for the 3x3 inverse block
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS
`define M3I_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("m3i check failed");
`define M3I_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("m3i check failed");
`else
`define M3I_ASSERT_SAME(name, pre, post)
`define M3I_ASSERT_NEXT(name, pre, post)
`endif

`endif

// ===== src/m3i_pkg.sv =====
package m3i_pkg;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;
    logic               singular;
    logic               clipped;
  } out_t;

  localparam int COF_W    = 64;
  localparam int DET_W    = 97;
  localparam int DMAG_W   = 96;
  localparam int QBITS    = 33;
  localparam int LANE_LAT = QBITS + 1;
  localparam int FRONT    = 5;
  localparam int LATENCY  = FRONT + LANE_LAT + 1;

endpackage

// ===== src/m3i_lane.sv =====
module m3i_lane
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic signed [COF_W-1:0] cof,
  input  logic [DMAG_W-1:0]       dmag,
  input  logic                    dneg,
  output logic [31:0]             res,
  output logic                    clip
);

  localparam int NUM_W = COF_W + 2 * FRAC_BITS;
  localparam int W     = DMAG_W + QBITS;

  logic [W-1:0]      rem_r [0:QBITS];
  logic [DMAG_W-1:0] d_r   [0:QBITS];
  logic [QBITS-1:0]  q_r   [0:QBITS];
  logic              neg_r [0:QBITS];
  logic              ovf_r [0:QBITS];

  logic [COF_W-1:0] mag;
  logic [NUM_W-1:0] num;
  logic [W:0]       num_ext;
  logic [W:0]       dtop;

  assign mag     = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
  assign num     = {mag, {(2 * FRAC_BITS){1'b0}}};
  assign num_ext = {{(W + 1 - NUM_W){1'b0}}, num};
  assign dtop    = {1'b0, dmag, {QBITS{1'b0}}};

  // a quotient of 2^33 or more saturates whatever its low bits are
  always_ff @(posedge clk) begin
    rem_r[0] <= num_ext[W-1:0];
    d_r[0]   <= dmag;
    q_r[0]   <= '0;
    neg_r[0] <= cof[COF_W-1] ^ dneg;
    ovf_r[0] <= (num_ext >= dtop);
  end

  for (genvar j = 1; j <= QBITS; j++) begin : g_stage
    logic [W-1:0] sh;
    logic         take;
    assign sh   = {{QBITS{1'b0}}, d_r[j-1]} << (QBITS - j);
    assign take = (rem_r[j-1] >= sh);
    always_ff @(posedge clk) begin
      rem_r[j] <= take ? rem_r[j-1] - sh : rem_r[j-1];
      d_r[j]   <= d_r[j-1];
      q_r[j]   <= {q_r[j-1][QBITS-2:0], take};
      neg_r[j] <= neg_r[j-1];
      ovf_r[j] <= ovf_r[j-1];
    end
  end

  logic [QBITS-1:0] lim;
  logic [QBITS-1:0] qm;

  always_comb begin
    lim  = neg_r[QBITS] ? QBITS'(33'h080000000) : QBITS'(33'h07FFFFFFF);
    clip = ovf_r[QBITS] || (q_r[QBITS] > lim);
    qm   = clip ? lim : q_r[QBITS];
    res  = neg_r[QBITS] ? 32'(-qm) : qm[31:0];
  end

endmodule

// ===== src/matrix3x3_inverse.sv =====
// channel  ports                        dir  word
// input    start, in_data; busy (out)   in   in_t: nine Q entries, row-major
// result   out_valid, out_data          out  out_t: inverse, singular, clipped
//
// One matrix is taken every cycle that start is high and busy is low; busy is high
// during reset and for the first cycle after it. Each result word passes through
// five product/determinant stages, 34 registers per divider lane (input
// register plus 33 restoring steps) and the output register.
// Reset is synchronous, active low, sets busy and clears the valid pipeline.
// The receiver cannot stall; out_valid lasts one cycle per word.
`include "matrix3x3_inverse_defines.svh"
module matrix3x3_inverse
  import m3i_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b1;
    else busy_r <= 1'b0;
  end
  assign busy = busy_r;

  logic take;
  assign take = start && !busy_r;

  // stage 1: products
  logic signed [63:0] p_r [0:17];
  logic signed [31:0] m1_r [0:2];
  always_ff @(posedge clk) begin
    p_r[0]  <= in_data.a11 * in_data.a22;  p_r[1]  <= in_data.a12 * in_data.a21;
    p_r[2]  <= in_data.a02 * in_data.a21;  p_r[3]  <= in_data.a01 * in_data.a22;
    p_r[4]  <= in_data.a01 * in_data.a12;  p_r[5]  <= in_data.a02 * in_data.a11;
    p_r[6]  <= in_data.a12 * in_data.a20;  p_r[7]  <= in_data.a10 * in_data.a22;
    p_r[8]  <= in_data.a00 * in_data.a22;  p_r[9]  <= in_data.a02 * in_data.a20;
    p_r[10] <= in_data.a02 * in_data.a10;  p_r[11] <= in_data.a00 * in_data.a12;
    p_r[12] <= in_data.a10 * in_data.a21;  p_r[13] <= in_data.a11 * in_data.a20;
    p_r[14] <= in_data.a01 * in_data.a20;  p_r[15] <= in_data.a00 * in_data.a21;
    p_r[16] <= in_data.a00 * in_data.a11;  p_r[17] <= in_data.a01 * in_data.a10;
    m1_r[0] <= in_data.a00;
    m1_r[1] <= in_data.a01;
    m1_r[2] <= in_data.a02;
  end

  // stage 2: transposed cofactors
  logic signed [COF_W-1:0] c2_r [0:8];
  logic signed [31:0]      m2_r [0:2];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) c2_r[k] <= p_r[2*k] - p_r[2*k+1];
    for (int k = 0; k < 3; k++) m2_r[k] <= m1_r[k];
  end

  // stage 3: determinant partial products, split at bit 32
  logic signed [64:0]      pl_r [0:2];
  logic signed [63:0]      ph_r [0:2];
  logic signed [COF_W-1:0] c3_r [0:8];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pl_r[k] <= m2_r[k] * $signed({1'b0, c2_r[3*k][31:0]});
      ph_r[k] <= m2_r[k] * $signed(c2_r[3*k][63:32]);
    end
    for (int k = 0; k < 9; k++) c3_r[k] <= c2_r[k];
  end

  // stage 4: determinant
  logic signed [DET_W-1:0] det_r;
  logic signed [COF_W-1:0] c4_r [0:8];
  logic signed [DET_W-1:0] det_nxt;
  always_comb begin
    det_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      det_nxt = det_nxt + $signed({ph_r[k][63], ph_r[k], 32'b0})
                        + $signed({{32{pl_r[k][64]}}, pl_r[k]});
    end
  end
  always_ff @(posedge clk) begin
    det_r <= det_nxt;
    for (int k = 0; k < 9; k++) c4_r[k] <= c3_r[k];
  end

  // stage 5: magnitude and sign of the determinant
  logic [DMAG_W-1:0]       dmag_r;
  logic                    dneg_r;
  logic                    sing5_r;
  logic signed [COF_W-1:0] c5_r [0:8];
  logic [DET_W-1:0]        dabs;
  assign dabs = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  always_ff @(posedge clk) begin
    dmag_r  <= dabs[DMAG_W-1:0];
    dneg_r  <= det_r[DET_W-1];
    sing5_r <= (det_r == '0);
    for (int k = 0; k < 9; k++) c5_r[k] <= c4_r[k];
  end

  logic [31:0] res  [0:8];
  logic [8:0]  clip;
  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk  (clk),
      .cof  (c5_r[k]),
      .dmag (dmag_r),
      .dneg (dneg_r),
      .res  (res[k]),
      .clip (clip[k])
    );
  end

  logic [LANE_LAT-1:0]        sing_r;
  logic [FRONT+LANE_LAT-1:0]  vld_r;
  always_ff @(posedge clk) begin
    sing_r <= {sing_r[LANE_LAT-2:0], sing5_r};
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[FRONT+LANE_LAT-2:0], take};
  end

  // merge: drop lane results when singular
  out_t out_r, out_nxt;
  logic out_valid_r;
  logic sing;
  always_comb begin
    sing = sing_r[LANE_LAT-1];
    out_nxt.r00 = sing ? '0 : res[0];
    out_nxt.r01 = sing ? '0 : res[1];
    out_nxt.r02 = sing ? '0 : res[2];
    out_nxt.r10 = sing ? '0 : res[3];
    out_nxt.r11 = sing ? '0 : res[4];
    out_nxt.r12 = sing ? '0 : res[5];
    out_nxt.r20 = sing ? '0 : res[6];
    out_nxt.r21 = sing ? '0 : res[7];
    out_nxt.r22 = sing ? '0 : res[8];
    out_nxt.singular = sing;
    out_nxt.clipped  = !sing && (|clip);
  end
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= vld_r[FRONT+LANE_LAT-1];
  end
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `M3I_ASSERT_SAME(a_sing_noclip, out_valid && out_data.singular, !out_data.clipped)
  `M3I_ASSERT_SAME(a_sing_zero, out_valid && out_data.singular, out_data.r00 == 32'd0 && out_data.r22 == 32'd0)
  `M3I_ASSERT_NEXT(a_lat, vld_r[FRONT+LANE_LAT-1], out_valid)
  `M3I_ASSERT_NEXT(a_ready, rst_n, !busy)

endmodule
